// ===== design/imu_motion_pulse_detector_defines.svh =====
// Assertion macros shared by the detector modules.
`ifndef IMU_MOTION_PULSE_DETECTOR_DEFINES_SVH
`define IMU_MOTION_PULSE_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, c, r, expr) \
  lbl: assert property (@(posedge c) disable iff (r) (expr)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, c, r, expr)
`define ASSERT_IMPLY(lbl, c, r, ante, cons)
`endif

`endif

// ===== design/imd_pkg.sv =====
// Types, constants and helper functions of the IMU motion pulse detector.
`default_nettype none
package imd_pkg;

  localparam int CAL_SAMPLES = 16;
  localparam int SAMPLE_BITS = 16;
  // floor(log2(CAL_SAMPLES))
  localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES + 1) - 1;
  localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
  localparam int AXIS_W      = 16;
  localparam int SUM_W       = 24;
  localparam int SQ_W        = 32;
  localparam int DEV_W       = 34;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [DEV_W-1:0] ACC_THR_RESET  = DEV_W'(42025);
  localparam logic [DEV_W-1:0] GYRO_THR_RESET = DEV_W'(6400);
  localparam logic [15:0]      WINDOW_RESET   = 16'd500;
  localparam logic [15:0]      STOP_RESET     = 16'd1000;
  localparam logic [7:0]       PULSES_RESET   = 8'd3;
  localparam logic [7:0]       MIN_GAP_RESET  = 8'd50;
  localparam logic [7:0]       TALLY_MAX      = 8'd255;

  typedef enum logic [1:0] {
    OP_DETECT = 2'd0,
    OP_CAL    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_IDLE   = 2'd3
  } imd_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACC_THR  = 3'd0,
    CFG_GYRO_THR = 3'd1,
    CFG_WINDOW   = 3'd2,
    CFG_STOP     = 3'd3,
    CFG_PULSES   = 3'd4,
    CFG_MIN_GAP  = 3'd5
  } imd_cfg_idx_t;

  // One classified sample: axes are already sign-extended from SAMPLE_BITS.
  typedef struct packed {
    imd_op_t                      op;
    logic [TIME_W-1:0]            time_ms;
    logic [5:0][AXIS_W-1:0]       axis;
  } imd_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } imd_q_stat_t;

  function automatic logic [AXIS_W-1:0] imd_sample_of(input logic [AXIS_W-1:0] raw);
    logic signed [SAMPLE_BITS-1:0] v;
    v = raw[SAMPLE_BITS-1:0];
    return AXIS_W'(v);
  endfunction

  // Floor average by arithmetic shift, clamped to the signed 16-bit range.
  function automatic logic [AXIS_W-1:0] imd_avg(input logic signed [SUM_W-1:0] sum);
    localparam logic signed [SUM_W-1:0] AVG_MAX = 32767;
    localparam logic signed [SUM_W-1:0] AVG_MIN = -32768;
    logic signed [SUM_W-1:0] q;
    q = sum >>> CAL_SHIFT;
    if (q > AVG_MAX) begin
      return 16'h7FFF;
    end else if (q < AVG_MIN) begin
      return 16'h8000;
    end
    return q[AXIS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/imd_ifs.sv =====
// Channel interfaces: sample input, result output and configuration write.
`default_nettype none
interface imd_sample_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [31:0]       time_ms;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  modport source (output valid, opcode, time_ms, acc_x, acc_y, acc_z,
                  gyro_x, gyro_y, gyro_z, input ready);
  modport sink   (input valid, opcode, time_ms, acc_x, acc_y, acc_z,
                  gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface imd_result_if;
  import imd_pkg::*;
  logic             valid;
  logic             ready;
  logic             moving;
  logic             is_calibrated;
  logic [DEV_W-1:0] acc_dev_sq;
  logic [DEV_W-1:0] gyro_dev_sq;
  logic [DEV_W-1:0] peak_acc_dev_sq;
  logic [DEV_W-1:0] peak_gyro_dev_sq;
  modport source (output valid, moving, is_calibrated, acc_dev_sq, gyro_dev_sq,
                  peak_acc_dev_sq, peak_gyro_dev_sq, input ready);
  modport sink   (input valid, moving, is_calibrated, acc_dev_sq, gyro_dev_sq,
                  peak_acc_dev_sq, peak_gyro_dev_sq, output ready);
endinterface

interface imd_cfg_if;
  import imd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DEV_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/imd_front.sv =====
// Front end: accepts samples, decodes the opcode and sign-extends the axes.
`default_nettype none
module imd_front (
  input  logic               clk,
  input  logic               rst,
  imd_sample_if.sink         samples,
  input  imd_pkg::imd_q_stat_t q_stat,
  output logic               push,
  output imd_pkg::imd_item_t item
);
  import imd_pkg::*;

  logic held;
  logic take;

  assign samples.ready = !held || !q_stat.full;
  assign take          = samples.valid && samples.ready;
  assign push          = held && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.op      <= imd_op_t'(samples.opcode);
      item.time_ms <= samples.time_ms;
      item.axis[0] <= imd_sample_of(samples.acc_x);
      item.axis[1] <= imd_sample_of(samples.acc_y);
      item.axis[2] <= imd_sample_of(samples.acc_z);
      item.axis[3] <= imd_sample_of(samples.gyro_x);
      item.axis[4] <= imd_sample_of(samples.gyro_y);
      item.axis[5] <= imd_sample_of(samples.gyro_z);
    end
  end

endmodule
`default_nettype wire

// ===== design/imd_queue.sv =====
// Small request queue between the front end and the execution back end.
`default_nettype none
`include "imu_motion_pulse_detector_defines.svh"
module imd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  imd_pkg::imd_item_t   push_item,
  input  logic                 pop,
  output imd_pkg::imd_item_t   head,
  output imd_pkg::imd_q_stat_t q_stat
);
  import imd_pkg::*;

  imd_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))
  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, !q_stat.full)
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !q_stat.empty)

endmodule
`default_nettype wire

// ===== design/imd_back.sv =====
// Back end: calibration, deviation squares, pulse and motion state, result register.
`default_nettype none
`include "imu_motion_pulse_detector_defines.svh"
module imd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  imd_pkg::imd_q_stat_t q_stat,
  input  imd_pkg::imd_item_t   head,
  output logic                 pop,
  imd_cfg_if.sink              cfg,
  imd_result_if.source         results
);
  import imd_pkg::*;

  typedef struct packed {
    imd_op_t                op;
    logic                   do_detect;
    logic                   cal_end;
    logic                   calibrated;
    logic [TIME_W-1:0]      time_ms;
    logic [5:0][SQ_W-1:0]   sq;
  } imd_stage_t;

  // Configuration registers
  logic [DEV_W-1:0] acc_thr;
  logic [DEV_W-1:0] gyro_thr;
  logic [15:0]      window_ms;
  logic [15:0]      stop_delay_ms;
  logic [7:0]       pulses_needed;
  logic [7:0]       min_gap_ms;

  // Calibration state
  logic [5:0][AXIS_W-1:0] baseline;
  logic [5:0][SUM_W-1:0]  sums;
  logic [CNT_W-1:0]       cal_count;
  logic                   calibrated;

  // Detection state
  logic              motion_active, motion_active_next;
  logic              window_open, window_open_next;
  logic [TIME_W-1:0] window_begin, window_begin_next;
  logic [TIME_W-1:0] last_motion_at, last_motion_at_next;
  logic [TIME_W-1:0] last_pulse_at, last_pulse_at_next;
  logic [7:0]        pulse_tally, pulse_tally_next;
  logic [DEV_W-1:0]  peak_acc, peak_acc_next;
  logic [DEV_W-1:0]  peak_gyro, peak_gyro_next;

  logic       advance;
  logic       a_valid;
  imd_stage_t a_stage, a_stage_next;
  logic       out_valid;

  logic [5:0][SUM_W-1:0] sums_add;
  logic [5:0][SQ_W-1:0]  lane_sq;
  logic [CNT_W-1:0]      cal_count_inc;
  logic                  cal_done;

  logic [DEV_W-1:0]  acc_sum, gyro_sum, ad, gd;
  logic [TIME_W-1:0] since_begin, since_pulse, since_motion;
  logic              hit;

  assign cfg.ready = 1'b1;
  assign advance   = !out_valid || results.ready;
  assign pop       = advance && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_thr       <= ACC_THR_RESET;
      gyro_thr      <= GYRO_THR_RESET;
      window_ms     <= WINDOW_RESET;
      stop_delay_ms <= STOP_RESET;
      pulses_needed <= PULSES_RESET;
      min_gap_ms    <= MIN_GAP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ACC_THR:  acc_thr       <= cfg.data;
        CFG_GYRO_THR: gyro_thr      <= cfg.data;
        CFG_WINDOW:   window_ms     <= cfg.data[15:0];
        CFG_STOP:     stop_delay_ms <= cfg.data[15:0];
        CFG_PULSES:   pulses_needed <= cfg.data[7:0];
        CFG_MIN_GAP:  min_gap_ms    <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Stage A: calibration update and per-axis squared deviations
  always_comb begin
    cal_count_inc = cal_count + 1'b1;
    cal_done      = (head.op == OP_CAL) && (cal_count_inc >= CNT_W'(CAL_SAMPLES));
    a_stage_next.op         = head.op;
    a_stage_next.do_detect  = (head.op == OP_DETECT) && calibrated;
    a_stage_next.cal_end    = cal_done;
    a_stage_next.calibrated = calibrated || cal_done;
    a_stage_next.time_ms    = head.time_ms;
    a_stage_next.sq         = lane_sq;
    for (int i = 0; i < 6; i++) begin
      sums_add[i] = sums[i] + SUM_W'(signed'(head.axis[i]));
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_lane
    logic signed [AXIS_W:0] diff;
    logic [AXIS_W-1:0]      mag;
    assign diff = (AXIS_W+1)'(signed'(head.axis[g])) - (AXIS_W+1)'(signed'(baseline[g]));
    assign mag  = diff[AXIS_W] ? AXIS_W'(-diff) : diff[AXIS_W-1:0];
    assign lane_sq[g] = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      sums       <= '0;
      cal_count  <= '0;
      calibrated <= 1'b0;
      baseline   <= '0;
    end else if (advance) begin
      a_valid <= pop;
      if (pop && head.op == OP_CAL) begin
        if (cal_done) begin
          for (int i = 0; i < 6; i++) begin
            baseline[i] <= imd_avg(sums_add[i]);
          end
          sums       <= '0;
          cal_count  <= '0;
          calibrated <= 1'b1;
        end else begin
          sums      <= sums_add;
          cal_count <= cal_count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_stage <= a_stage_next;
    end
  end

  // Stage B: sums, thresholds, peaks, pulse window and motion
  always_comb begin
    acc_sum  = DEV_W'(a_stage.sq[0]) + DEV_W'(a_stage.sq[1]) + DEV_W'(a_stage.sq[2]);
    gyro_sum = DEV_W'(a_stage.sq[3]) + DEV_W'(a_stage.sq[4]) + DEV_W'(a_stage.sq[5]);
    since_begin  = a_stage.time_ms - window_begin;
    since_pulse  = a_stage.time_ms - last_pulse_at;
    since_motion = a_stage.time_ms - last_motion_at;
    ad  = '0;
    gd  = '0;
    hit = 1'b0;
    motion_active_next  = motion_active;
    window_open_next    = window_open;
    window_begin_next   = window_begin;
    last_motion_at_next = last_motion_at;
    last_pulse_at_next  = last_pulse_at;
    pulse_tally_next    = pulse_tally;
    peak_acc_next       = peak_acc;
    peak_gyro_next      = peak_gyro;
    if (a_stage.cal_end) begin
      peak_acc_next    = '0;
      peak_gyro_next   = '0;
      pulse_tally_next = '0;
      window_open_next = 1'b0;
    end else if (a_stage.op == OP_CLEAR) begin
      peak_acc_next  = '0;
      peak_gyro_next = '0;
    end else if (a_stage.do_detect) begin
      ad = acc_sum;
      gd = gyro_sum;
      if (ad > peak_acc) begin
        peak_acc_next = ad;
      end
      if (gd > peak_gyro) begin
        peak_gyro_next = gd;
      end
      hit = (ad > acc_thr) || (gd > gyro_thr);
      if (hit) begin
        last_motion_at_next = a_stage.time_ms;
        if (!window_open) begin
          window_open_next  = 1'b1;
          window_begin_next = a_stage.time_ms;
          pulse_tally_next  = 8'd1;
        end else if (since_begin <= TIME_W'(window_ms)) begin
          if (since_pulse > TIME_W'(min_gap_ms)) begin
            if (pulse_tally != TALLY_MAX) begin
              pulse_tally_next = pulse_tally + 1'b1;
            end
            last_pulse_at_next = a_stage.time_ms;
          end
        end else begin
          window_begin_next = a_stage.time_ms;
          pulse_tally_next  = 8'd1;
        end
        if (pulse_tally_next >= pulses_needed) begin
          motion_active_next = 1'b1;
        end
      end else begin
        // drop a stale window while idle
        if (!motion_active && window_open && since_begin > TIME_W'(window_ms)) begin
          window_open_next = 1'b0;
          pulse_tally_next = '0;
        end
        if (motion_active && since_motion > TIME_W'(stop_delay_ms)) begin
          motion_active_next = 1'b0;
          window_open_next   = 1'b0;
          pulse_tally_next   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      motion_active  <= 1'b0;
      window_open    <= 1'b0;
      window_begin   <= '0;
      last_motion_at <= '0;
      last_pulse_at  <= '0;
      pulse_tally    <= '0;
      peak_acc       <= '0;
      peak_gyro      <= '0;
    end else if (advance) begin
      out_valid <= a_valid;
      if (a_valid) begin
        motion_active  <= motion_active_next;
        window_open    <= window_open_next;
        window_begin   <= window_begin_next;
        last_motion_at <= last_motion_at_next;
        last_pulse_at  <= last_pulse_at_next;
        pulse_tally    <= pulse_tally_next;
        peak_acc       <= peak_acc_next;
        peak_gyro      <= peak_gyro_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid) begin
      results.moving           <= motion_active_next;
      results.is_calibrated    <= a_stage.calibrated;
      results.acc_dev_sq       <= ad;
      results.gyro_dev_sq      <= gd;
      results.peak_acc_dev_sq  <= peak_acc_next;
      results.peak_gyro_dev_sq <= peak_gyro_next;
    end
  end

  assign results.valid = out_valid;

  `ASSERT_IMPLY(a_uncal_zero_dev, clk, rst, out_valid && !results.is_calibrated,
                results.acc_dev_sq == '0 && results.gyro_dev_sq == '0)
  `ASSERT_IMPLY(a_peak_covers_dev, clk, rst, out_valid,
                results.peak_acc_dev_sq >= results.acc_dev_sq &&
                results.peak_gyro_dev_sq >= results.gyro_dev_sq)
  `ASSERT_IMPLY(a_closed_window_empty, clk, rst, !window_open, pulse_tally == '0)

endmodule
`default_nettype wire

// ===== design/imu_motion_pulse_detector.sv =====
// Top level of the IMU motion pulse detector.
//
//  channel   role    handshake          payload
//  samples   sink    valid / ready      opcode, time_ms, acc_x..z, gyro_x..z
//  results   source  valid / ready      moving, is_calibrated, four squared deviations
//  cfg       sink    valid / ready(=1)  index (3 bit), data (34 bit)
//
// One sample is accepted per cycle when the result side keeps up; its result
// passes through the input register, the queue, the square stage and the result
// register. The state update of stage B sets that rate.
// rst is synchronous, clears all control and detection state and restores register defaults.
// A held result stalls the back end; the four-entry queue and the input
// register then fill before samples.ready drops.
`default_nettype none
module imu_motion_pulse_detector (
  input  logic         clk,
  input  logic         rst,
  imd_sample_if.sink   samples,
  imd_result_if.source results,
  imd_cfg_if.sink      cfg
);
  import imd_pkg::*;

  imd_item_t   item;
  imd_item_t   head;
  imd_q_stat_t q_stat;
  logic        push;
  logic        pop;

  imd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_stat  (q_stat),
    .push    (push),
    .item    (item)
  );

  imd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  imd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .head    (head),
    .pop     (pop),
    .cfg     (cfg),
    .results (results)
  );

endmodule
`default_nettype wire
